@@ rtl/length_prefixed_ring_queue_top_macros.svh @@
// Assertion helpers for the ring queue top level.
// Both expect clk and rst_n in scope.
`ifndef LENGTH_PREFIXED_RING_QUEUE_TOP_MACROS_SVH
`define LENGTH_PREFIXED_RING_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define LPRQ_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPRQ_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lprq_pkg.sv @@
`default_nettype none

package lprq_pkg;

    localparam int BUFFER_WORDS_DEF = 64;
    localparam int CMDQ_DEPTH       = 2;
    localparam int RESQ_DEPTH       = 4;

    localparam logic [8:0] MAX_ADV_RESET = 9'd256;

    // input mode codes
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_FETCH   = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // result kind codes
    localparam logic [1:0] KIND_ACCEPT      = 2'd0;
    localparam logic [1:0] KIND_REJECT      = 2'd1;
    localparam logic [1:0] KIND_FETCH_EMPTY = 2'd2;
    localparam logic [1:0] KIND_WORD        = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  request_size;
        logic [31:0] data_word;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_word;
        logic [7:0]  batch_bytes;
        logic        last;
        logic        now_empty;
    } res_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_PAYLOAD,
        OP_FETCH
    } op_t;

    // classified item between front and back
    typedef struct packed {
        op_t         op;
        logic [6:0]  rec_words;   // header + payload words
        logic [31:0] data_word;
    } op_item_t;

    // back end to result queue
    typedef struct packed {
        logic push;
        res_t item;
    } res_wr_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/lprq_fifo.sv @@
`default_nettype none

module lprq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             wdata,
    output logic                              full,
    input  wire logic                         pop,
    output logic [WIDTH-1:0]                  rdata,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

@@ rtl/lprq_front.sv @@
`default_nettype none

module lprq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lprq_pkg::cmd_t     cmd,
    output logic                    full,
    input  wire logic               q_pop,
    output lprq_pkg::op_item_t      q_item,
    output logic                    q_empty
);

    import lprq_pkg::*;

    localparam int QW = $bits(op_item_t);

    op_item_t    cls_item;
    logic        cls_keep;
    logic        q_full;
    logic [8:0]  req_round;
    logic [QW-1:0] q_rdata;

    // mode decode and record sizing
    always_comb
    begin
        req_round          = ({1'b0, cmd.request_size} + 9'd3) >> 2;
        cls_item.rec_words = 7'(req_round) + 7'd1;
        cls_item.data_word = cmd.data_word;
        cls_item.op        = OP_PAYLOAD;
        cls_keep           = 1'b1;
        unique case (cmd.mode)
            MODE_INSERT:  cls_item.op = OP_INSERT;
            MODE_PAYLOAD: cls_item.op = OP_PAYLOAD;
            MODE_FETCH:   cls_item.op = OP_FETCH;
            MODE_UNUSED:  cls_keep    = 1'b0;   // dropped at the door
            default:      cls_keep    = 1'b0;
        endcase
    end

    assign full   = q_full;
    assign q_item = op_item_t'(q_rdata);

    lprq_fifo #(
        .WIDTH (QW),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && cls_keep),
        .wdata (cls_item),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count ()
    );

endmodule

`default_nettype wire

@@ rtl/lprq_back.sv @@
`default_nettype none

module lprq_back #(
    parameter int BUFFER_WORDS = lprq_pkg::BUFFER_WORDS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [8:0]                             cfg_wdata,
    input  wire logic                                   cmd_valid,
    input  wire lprq_pkg::op_item_t                     cmd_item,
    output logic                                        cmd_pop,
    input  wire logic [$clog2(lprq_pkg::RESQ_DEPTH+1)-1:0] res_count,
    output lprq_pkg::res_wr_t                           res_wr
);

    import lprq_pkg::*;

    localparam int PW = $clog2(BUFFER_WORDS);
    localparam int CW = $clog2(RESQ_DEPTH + 1);

    back_state_t state_reg, state_next;

    logic [31:0]           mem_reg [BUFFER_WORDS];
    logic [BUFFER_WORDS-1:0] vld_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [6:0]    wl_reg, wl_next;
    logic          open_reg, open_next;
    logic [8:0]    mab_reg;

    logic [PW-1:0] fidx_reg, fidx_next;
    logic [PW-1:0] fleft_reg, fleft_next;
    logic [PW-1:0] bwords_reg, bwords_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg, rd_last_next;
    logic [31:0]   rd_data_reg;
    logic          rd_vld_reg;

    logic          mem_we, mem_re;
    logic [PW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    logic [PW:0]   diff;
    logic [PW-1:0] used_w;
    logic          ok_adv, ok_cap, ins_ok;
    logic [7:0]    tail_sum, tail_wrap;
    logic          res_room;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(BUFFER_WORDS - 1)) ? '0 : p + PW'(1);
    endfunction

    // occupancy and insert admission
    always_comb
    begin
        if (tail_reg >= head_reg)
            diff = {1'b0, tail_reg} - {1'b0, head_reg};
        else
            diff = {1'b0, tail_reg} + (PW+1)'(BUFFER_WORDS) - {1'b0, head_reg};
        used_w    = diff[PW-1:0];
        ok_adv    = ((10'(used_w) << 2) + (10'(cmd_item.rec_words) << 2)) < 10'(mab_reg);
        ok_cap    = (8'(used_w) + 8'(cmd_item.rec_words)) <= 8'(BUFFER_WORDS);
        ins_ok    = ok_adv && ok_cap;
        tail_sum  = 8'(tail_reg) + 8'(cmd_item.rec_words);
        tail_wrap = (tail_sum >= 8'(BUFFER_WORDS)) ? tail_sum - 8'(BUFFER_WORDS) : tail_sum;
        res_room  = ((CW+1)'(res_count) + (CW+1)'(rd_pend_reg)) < (CW+1)'(RESQ_DEPTH);
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        wp_next      = wp_reg;
        wl_next      = wl_reg;
        open_next    = open_reg;
        fidx_next    = fidx_reg;
        fleft_next   = fleft_reg;
        bwords_next  = bwords_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = tail_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        cmd_pop      = 1'b0;
        res_wr       = '0;

        // word read last cycle goes out now
        if (rd_pend_reg)
        begin
            res_wr.push             = 1'b1;
            res_wr.item.kind        = KIND_WORD;
            res_wr.item.out_word    = rd_vld_reg ? rd_data_reg : '0;
            res_wr.item.batch_bytes = 8'({bwords_reg, 2'b00});
            res_wr.item.last        = rd_last_reg;
            res_wr.item.now_empty   = (head_reg == tail_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !rd_pend_reg && res_room)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_item.op)
                        OP_INSERT:
                        begin
                            wl_next = cmd_item.rec_words - 7'd1;
                            if (ins_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = tail_reg;
                                mem_wdata = 32'({cmd_item.rec_words, 2'b00});
                                wp_next   = wrap_inc(tail_reg);
                                tail_next = tail_wrap[PW-1:0];
                                open_next = 1'b1;
                            end
                            else
                                open_next = 1'b0;
                            res_wr.push           = 1'b1;
                            res_wr.item.kind      = ins_ok ? KIND_ACCEPT : KIND_REJECT;
                            res_wr.item.now_empty = (head_reg == tail_next);
                        end
                        OP_PAYLOAD:
                        begin
                            if (wl_reg != '0)
                            begin
                                if (open_reg)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = wp_reg;
                                    mem_wdata = cmd_item.data_word;
                                    wp_next   = wrap_inc(wp_reg);
                                end
                                wl_next = wl_reg - 7'd1;
                                if (wl_reg == 7'd1)
                                    open_next = 1'b0;
                            end
                        end
                        OP_FETCH:
                        begin
                            if (head_reg == tail_reg || (open_reg && wl_reg != '0))
                            begin
                                res_wr.push           = 1'b1;
                                res_wr.item.kind      = KIND_FETCH_EMPTY;
                                res_wr.item.last      = 1'b1;
                                res_wr.item.now_empty = (head_reg == tail_reg);
                            end
                            else
                            begin
                                fidx_next   = head_reg;
                                fleft_next  = used_w;
                                bwords_next = used_w;
                                head_next   = tail_reg;
                                state_next  = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (res_room)
                begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (fleft_reg == PW'(1));
                    fidx_next    = wrap_inc(fidx_reg);
                    fleft_next   = fleft_reg - PW'(1);
                    if (fleft_reg == PW'(1))
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            wp_reg      <= '0;
            wl_reg      <= '0;
            open_reg    <= 1'b0;
            mab_reg     <= MAX_ADV_RESET;
            fidx_reg    <= '0;
            fleft_reg   <= '0;
            bwords_reg  <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            wp_reg      <= wp_next;
            wl_reg      <= wl_next;
            open_reg    <= open_next;
            fidx_reg    <= fidx_next;
            fleft_reg   <= fleft_next;
            bwords_reg  <= bwords_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            if (cfg_we)
                mab_reg <= cfg_wdata;
            // fetch reads clear the word; no write happens during a fetch
            if (mem_we)
                vld_reg[mem_waddr] <= 1'b1;
            if (mem_re)
                vld_reg[fidx_reg] <= 1'b0;
        end
    end

    // word store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_reg[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_data_reg <= mem_reg[fidx_reg];
            rd_vld_reg  <= vld_reg[fidx_reg];
        end
    end

endmodule

`default_nettype wire

@@ rtl/length_prefixed_ring_queue_top.sv @@
`default_nettype none
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  -----------------------------
//  cmd       in         push / full            cmd_t: mode, size, data word
//  result    out        pop / empty            res_t: kind, word, bytes, ...
//  config    in         cfg_we (no wait)       cfg_wdata: max advance bytes
//
//  Insert header, payload word: back end takes 1 item/cycle when not stalled.
//  Fetch of N words: the start moves head to tail, then 1 word/cycle off the store's
//  single registered read port while the result queue has room.
//  Reset: all queues empty, ring empty, every store word reads as zero.
//  Stalls: the back end holds while the result queue has no free slot
//  (a word read from the store counts as one); the 2-entry command
//  queue keeps taking items until it fills.
//
`include "length_prefixed_ring_queue_top_macros.svh"

module length_prefixed_ring_queue_top #(
    parameter int BUFFER_WORDS = lprq_pkg::BUFFER_WORDS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lprq_pkg::cmd_t cmd,
    output logic                full,
    input  wire logic           pop,
    output lprq_pkg::res_t      result,
    output logic                empty,
    input  wire logic           cfg_we,
    input  wire logic [8:0]     cfg_wdata
);

    import lprq_pkg::*;

    localparam int RW = $bits(res_t);
    localparam int CW = $clog2(RESQ_DEPTH + 1);

    // front -> back classified items
    op_item_t      q_item;
    logic          q_empty;
    logic          q_pop;

    // back -> result queue
    res_wr_t       res_wr;
    logic          res_full;
    logic [CW-1:0] res_count;
    logic [RW-1:0] res_rdata;

    // Front: decodes mode, sizes the record, drops unused codes.
    lprq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd     (cmd),
        .full    (full),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .q_empty (q_empty)
    );

    // Back: ring state, word store, fetch sequencer.
    lprq_back #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (!q_empty),
        .cmd_item  (q_item),
        .cmd_pop   (q_pop),
        .res_count (res_count),
        .res_wr    (res_wr)
    );

    // Result queue; back end only pushes with room reserved for the
    // word in flight from the store.
    lprq_fifo #(
        .WIDTH (RW),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_wr.push),
        .wdata (res_wr.item),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty),
        .count (res_count)
    );

    assign result = res_t'(res_rdata);

    // credit accounting must never overrun the result queue
    `LPRQ_AST_NOW(a_res_no_overflow, res_wr.push, !res_full, "result queue overrun")
    // fetched words leave the ring empty
    `LPRQ_AST_NOW(a_word_now_empty, !empty && result.kind == KIND_WORD, result.now_empty,
                  "fetched word without empty ring")
    // a pushed fetch-empty result is waiting in the result queue next cycle
    `LPRQ_AST_NEXT(a_empty_last, res_wr.push && res_wr.item.kind == KIND_FETCH_EMPTY,
                   !empty, "fetch-empty result lost")

endmodule

`default_nettype wire

@@ test/length_prefixed_ring_queue_top_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_ring_queue_top_tb;

    import lprq_pkg::*;

    localparam int RING_WORDS    = BUFFER_WORDS_DEF;
    localparam int SETTLE_CYCLES = 16;        // command queue + fetch start + read latency
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 50;

    // directed rows: a register write, an item checked against the ring model,
    // or an item whose single result is spelled out in the row
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t  rk;
        logic [8:0] cfg;
        cmd_t       c;
        res_t       want;
    } dir_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    cmd_t       cmd       = '0;
    logic       full;
    logic       pop       = 1'b0;
    res_t       result;
    logic       empty;
    logic       cfg_we    = 1'b0;
    logic [8:0] cfg_wdata = MAX_ADV_RESET;

    // ring model state
    logic [31:0] ring_store [RING_WORDS];
    logic [5:0]  ring_head;
    logic [5:0]  ring_tail;
    logic [5:0]  ring_wr;
    int          ring_words_left;
    bit          ring_insert_open;
    int          ring_max_adv;

    res_t     step_out[$];         // results of the item just accepted
    res_t     pending_results[$];  // results still owed by the block, oldest first
    dir_row_t dir_rows[$];

    bit     idle_on = 1'b1;
    int     pop_hold = 0;
    int     fails = 0;
    longint cycle_count = 0;

    length_prefixed_ring_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic cmd_t mk_cmd(logic [1:0] mode, logic [7:0] sz, logic [31:0] w);
        cmd_t c;
        c.mode         = mode;
        c.request_size = sz;
        c.data_word    = w;
        return c;
    endfunction

    // now_empty reflects the pointers after the state update, as the block reports it
    function automatic void note_result(logic [1:0] k, logic [31:0] w, logic [7:0] b,
                                        logic l);
        res_t r;
        r.kind        = k;
        r.out_word    = w;
        r.batch_bytes = b;
        r.last        = l;
        r.now_empty   = (ring_head == ring_tail);
        step_out.push_back(r);
    endfunction

    function automatic void ring_reset();
        foreach (ring_store[i])
            ring_store[i] = '0;
        ring_head        = '0;
        ring_tail        = '0;
        ring_wr          = '0;
        ring_words_left  = 0;
        ring_insert_open = 1'b0;
        ring_max_adv     = int'(MAX_ADV_RESET);
    endfunction

    // Advance the ring model by one accepted item; results land in step_out.
    function automatic void ring_model_step(cmd_t c);
        int         rec_bytes;
        int         used;
        int         cnt;
        bit         ok;
        logic [5:0] idx;
        logic [5:0] span;
        step_out.delete();
        span = ring_tail - ring_head;
        used = int'(span) * 4;
        case (c.mode)
            MODE_INSERT:
            begin
                rec_bytes = ((int'(c.request_size) + 7) / 4) * 4;
                ok = (used + rec_bytes < ring_max_adv) && (rec_bytes <= 4 * RING_WORDS - used);
                ring_words_left = (rec_bytes - 4) / 4;
                if (ok)
                begin
                    ring_store[ring_tail] = 32'(rec_bytes);
                    ring_wr               = ring_tail + 6'd1;
                    ring_tail             = ring_tail + 6'(rec_bytes / 4);
                    ring_insert_open      = 1'b1;
                end
                else
                    ring_insert_open = 1'b0;
                note_result(ok ? KIND_ACCEPT : KIND_REJECT, '0, '0, 1'b0);
            end
            MODE_PAYLOAD:
            begin
                if (ring_words_left > 0)
                begin
                    if (ring_insert_open)
                    begin
                        ring_store[ring_wr] = c.data_word;
                        ring_wr             = ring_wr + 6'd1;
                    end
                    ring_words_left--;
                    if (ring_words_left == 0)
                        ring_insert_open = 1'b0;
                end
            end
            MODE_FETCH:
            begin
                // an incomplete record blocks the whole fetch
                if (ring_head == ring_tail || (ring_insert_open && ring_words_left > 0))
                    note_result(KIND_FETCH_EMPTY, '0, '0, 1'b1);
                else
                begin
                    cnt       = int'(span);
                    idx       = ring_head;
                    ring_head = ring_tail;
                    for (int i = 0; i < cnt; i++)
                    begin
                        note_result(KIND_WORD, ring_store[idx], 8'(cnt * 4), i == cnt - 1);
                        ring_store[idx] = '0;
                        idx             = idx + 6'd1;
                    end
                end
            end
            default: ;  // unused mode: no effect
        endcase
    endfunction

    function automatic void add_row(row_kind_t rk, logic [1:0] mode, logic [7:0] sz,
                                    logic [31:0] w, logic [1:0] k, logic l, logic e);
        dir_row_t r;
        r.rk   = rk;
        r.cfg  = w[8:0];  // register value for ROW_CFG rows
        r.c    = mk_cmd(mode, sz, w);
        r.want = '0;
        r.want.kind      = k;
        r.want.last      = l;
        r.want.now_empty = e;
        dir_rows.push_back(r);
    endfunction

    // Offer one item, optionally after a random gap, and hold it until accepted.
    task automatic send_item(input cmd_t c, input bit typed, input res_t want);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push <= 1'b1;
        cmd  <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ring_model_step(c);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_out[i])
                pending_results.push_back(step_out[i]);
    endtask

    // Stop sending, let every owed result come out, then let payload items settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_advance(input logic [8:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        ring_max_adv = int'(v);
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: kind %0d word %h", got.kind, got.out_word);
            fails++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                fails++;
            end
            if (got.out_word !== want.out_word)
            begin
                $error("out_word: expected %h, actual %h", want.out_word, got.out_word);
                fails++;
            end
            if (got.batch_bytes !== want.batch_bytes)
            begin
                $error("batch_bytes: expected %0d, actual %0d", want.batch_bytes,
                       got.batch_bytes);
                fails++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                fails++;
            end
            if (got.now_empty !== want.now_empty)
            begin
                $error("now_empty: expected %0d, actual %0d", want.now_empty, got.now_empty);
                fails++;
            end
        end
    endtask

    // Result side: take an item on every pop edge, stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_result(result);
        if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 15) == 0)
        begin
            pop_hold = $urandom_range(1, 13) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    initial
    begin
        logic [8:0] phase_cfg [NUM_PHASES];
        int         n;
        int         k;
        int         sz;
        int         pay;

        ring_reset();

        // Directed part, starting from reset (limit 256).
        add_row(ROW_TYPED, MODE_FETCH,   8'd0,   32'h0,         KIND_FETCH_EMPTY, 1'b1, 1'b1);
        add_row(ROW_ITEM,  MODE_PAYLOAD, 8'd0,   32'h1234_5678, '0, 1'b0, 1'b0);  // stray payload
        add_row(ROW_ITEM,  MODE_UNUSED,  8'hFF,  32'hFFFF_FFFF, '0, 1'b0, 1'b0);
        add_row(ROW_TYPED, MODE_INSERT,  8'd255, 32'hFFFF_FFFF, KIND_REJECT, 1'b0, 1'b1);
        add_row(ROW_ITEM,  MODE_PAYLOAD, 8'hFF,  32'hFFFF_FFFF, '0, 1'b0, 1'b0);  // dropped
        add_row(ROW_TYPED, MODE_INSERT,  8'd0,   32'h0,         KIND_ACCEPT, 1'b0, 1'b0);
        add_row(ROW_TYPED, MODE_INSERT,  8'd5,   32'h0,         KIND_ACCEPT, 1'b0, 1'b0);
        // record still waiting for payload: fetch holds off
        add_row(ROW_TYPED, MODE_FETCH,   8'd0,   32'h0,         KIND_FETCH_EMPTY, 1'b1, 1'b0);
        add_row(ROW_ITEM,  MODE_PAYLOAD, 8'd0,   32'hFFFF_FFFF, '0, 1'b0, 1'b0);
        // new header cuts the previous record short
        add_row(ROW_TYPED, MODE_INSERT,  8'd3,   32'h0,         KIND_ACCEPT, 1'b0, 1'b0);
        add_row(ROW_ITEM,  MODE_PAYLOAD, 8'd0,   32'h0,         '0, 1'b0, 1'b0);
        add_row(ROW_ITEM,  MODE_FETCH,   8'd0,   32'h0,         '0, 1'b0, 1'b0);
        // 256-byte record reaches the limit exactly
        add_row(ROW_TYPED, MODE_INSERT,  8'd251, 32'h0,         KIND_REJECT, 1'b0, 1'b1);
        add_row(ROW_TYPED, MODE_FETCH,   8'd0,   32'h0,         KIND_FETCH_EMPTY, 1'b1, 1'b1);
        add_row(ROW_TYPED, MODE_INSERT,  8'd247, 32'h0,         KIND_ACCEPT, 1'b0, 1'b0);
        add_row(ROW_TYPED, MODE_FETCH,   8'd0,   32'h0,         KIND_FETCH_EMPTY, 1'b1, 1'b0);
        add_row(ROW_TYPED, MODE_INSERT,  8'd8,   32'h0,         KIND_REJECT, 1'b0, 1'b0);
        add_row(ROW_ITEM,  MODE_FETCH,   8'd0,   32'h0,         '0, 1'b0, 1'b0);  // 63-word batch
        // limit above ring size: a 256-byte record wraps tail onto head
        add_row(ROW_CFG,   MODE_INSERT,  8'd0,   32'd511,       '0, 1'b0, 1'b0);
        add_row(ROW_TYPED, MODE_INSERT,  8'd252, 32'h0,         KIND_ACCEPT, 1'b0, 1'b1);
        add_row(ROW_TYPED, MODE_FETCH,   8'd0,   32'h0,         KIND_FETCH_EMPTY, 1'b1, 1'b1);
        add_row(ROW_TYPED, MODE_INSERT,  8'd0,   32'h0,         KIND_ACCEPT, 1'b0, 1'b0);
        add_row(ROW_ITEM,  MODE_FETCH,   8'd0,   32'h0,         '0, 1'b0, 1'b0);
        // smallest limit
        add_row(ROW_CFG,   MODE_INSERT,  8'd0,   32'd8,         '0, 1'b0, 1'b0);
        add_row(ROW_TYPED, MODE_INSERT,  8'd0,   32'h0,         KIND_ACCEPT, 1'b0, 1'b0);
        add_row(ROW_TYPED, MODE_INSERT,  8'd1,   32'h0,         KIND_REJECT, 1'b0, 1'b0);
        add_row(ROW_ITEM,  MODE_PAYLOAD, 8'd0,   32'hA5A5_5A5A, '0, 1'b0, 1'b0);
        add_row(ROW_ITEM,  MODE_FETCH,   8'd0,   32'h0,         '0, 1'b0, 1'b0);

        phase_cfg[0] = 9'd256;
        phase_cfg[1] = 9'd8;
        phase_cfg[2] = 9'($urandom_range(8, 256));
        phase_cfg[3] = 9'd511;
        phase_cfg[4] = 9'($urandom_range(8, 256));
        phase_cfg[5] = 9'd256;
        phase_cfg[6] = 9'd40;
        phase_cfg[7] = 9'($urandom_range(8, 256));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].rk)
                ROW_CFG:   write_max_advance(dir_rows[i].cfg);
                ROW_ITEM:  send_item(dir_rows[i].c, 1'b0, '0);
                default:   send_item(dir_rows[i].c, 1'b1, dir_rows[i].want);
            endcase
        end

        // Random part: each phase drains, sets a new limit, then mostly sends
        // complete records (header plus its payload) mixed with fetches,
        // truncated records, stray payload and unused-mode noise.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_max_advance(phase_cfg[p]);
            idle_on = (p != NUM_PHASES - 1) && (p % 3 != 2);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                k = $urandom_range(0, 99);
                if (k < 65 || (k >= 80 && k < 88))
                begin
                    sz  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 40);
                    pay = (sz + 3) / 4;
                    send_item(mk_cmd(MODE_INSERT, 8'(sz), $urandom), 1'b0, '0);
                    n++;
                    if (k >= 80 && pay > 0)
                        pay = $urandom_range(0, pay - 1);  // cut short
                    for (int i = 0; i < pay; i++)
                    begin
                        send_item(mk_cmd(MODE_PAYLOAD, 8'($urandom), $urandom), 1'b0, '0);
                        n++;
                    end
                    if (k >= 80 && $urandom_range(0, 1) == 1)
                    begin
                        send_item(mk_cmd(MODE_FETCH, 8'($urandom), $urandom), 1'b0, '0);
                        n++;
                    end
                end
                else if (k < 80)
                begin
                    send_item(mk_cmd(MODE_FETCH, 8'($urandom), $urandom), 1'b0, '0);
                    n++;
                end
                else if (k < 94)
                    send_item(mk_cmd(MODE_PAYLOAD, 8'($urandom), $urandom), 1'b0, '0);
                else
                    send_item(mk_cmd(MODE_UNUSED, 8'($urandom), $urandom), 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ length_prefixed_ring_queue_top.f @@
+incdir+rtl
rtl/lprq_pkg.sv
rtl/lprq_fifo.sv
rtl/lprq_front.sv
rtl/lprq_back.sv
rtl/length_prefixed_ring_queue_top.sv
test/length_prefixed_ring_queue_top_tb.sv
